// ===== rtl/core/mtfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfc_pkg
// Shared types and constants for the move-to-front codec.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfc_pkg;

  localparam int SYM_W         = 8;
  localparam int LIST_SIZE_DEF = 256;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [SYM_W-1:0] sym_t;

  // One node of the search tree: a hit flag and the matching entry's
  // position and symbol, zero where there is no hit.
  typedef struct packed {
    logic hit;
    sym_t pos;
    sym_t sym;
  } node_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic upd;
    logic init;
    sym_t pos;
    sym_t sym;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtfc_cell.sv =====
// ----------------------------------------------------------------------------
// mtfc_cell
// One recency-list entry: local match against the current beat and a
// one-step shift from the neighbour on promote.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_cell
  import mtfc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mode,
  input  wire sym_t      key,
  input  wire sym_t      pos,
  input  wire cell_ctl_t ctl,
  input  wire sym_t      left_val,
  output sym_t           val,
  output node_t          leaf
);

  localparam sym_t MY_IDX = SYM_W'(IDX);

  sym_t val_r;
  sym_t val_nxt;
  logic hit;

  assign val = val_r;

  always_comb begin
    if (mode == MODE_DECODE) begin
      hit = (MY_IDX == pos);
    end else begin
      hit = (val_r == key);
    end
    leaf.hit = hit;
    leaf.pos = hit ? MY_IDX : '0;
    leaf.sym = hit ? val_r : '0;
  end

  always_comb begin
    val_nxt = val_r;
    if (ctl.init) begin
      val_nxt = MY_IDX;
    end else if (ctl.upd) begin
      if (IDX == 0) begin
        val_nxt = ctl.sym;
      end else if (MY_IDX <= ctl.pos) begin
        val_nxt = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= MY_IDX;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtfc_tree.sv =====
// ----------------------------------------------------------------------------
// mtfc_tree
// Registered binary OR tree that gathers the single matching cell into one
// node, one level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_tree
  import mtfc_pkg::*;
#(
  parameter int LEAVES = LIST_SIZE_DEF
) (
  input  wire logic  clk,
  input  wire node_t leaf [LEAVES],
  output node_t      root
);

  localparam int P = 1 << $clog2(LEAVES);

  node_t node_r [2*P-1:1];

  for (genvar k = P; k < 2*P; k++) begin : g_leaf
    if (k - P < LEAVES) begin : g_used
      always_ff @(posedge clk) begin
        node_r[k] <= leaf[k-P];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    always_ff @(posedge clk) begin
      node_r[k] <= node_t'(node_r[2*k] | node_r[2*k+1]);
    end
  end

  assign root = node_r[1];

endmodule

`default_nettype wire

// ===== rtl/core/move_to_front_codec.sv =====
// ----------------------------------------------------------------------------
// move_to_front_codec
// Byte-wise move-to-front encoder and decoder over a recency list.
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_SIZE cells, one entry each, reset to the
// identity. cfg_wr_data selects encode (0: symbol in, position out) or
// decode (1: position in, symbol out; positions past the end saturate to
// the last entry); write it only while no beat is in flight. Each cell
// compares its entry (encode) or its index (decode) against the beat, a
// registered OR tree of clog2(LIST_SIZE) levels gathers the match, and
// once the output register is free the cells shift and the output
// register loads. The next input beat is taken in the cycle the result
// appears, even if it is not yet taken. An encode symbol not in the list
// gives 0 and leaves the list alone. in_tlast returns the list to the
// identity after its item.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_codec
  import mtfc_pkg::*;
#(
  parameter int LIST_SIZE = LIST_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,   // mode
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [SYM_W-1:0] in_tdata,      // data_in[7:0]
  input  wire logic             in_tlast,      // last_in_block
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [SYM_W-1:0] out_tdata,     // data_out[7:0]
  output logic                  out_tlast      // last_out
);

  localparam int   LEVELS = $clog2(LIST_SIZE);
  localparam int   CNT_W  = $clog2(LEVELS + 1);
  localparam sym_t MAX_POS = SYM_W'(LIST_SIZE - 1);

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic       mode_r;
  sym_t       key_r;
  sym_t       pos_r;
  logic       last_r;
  logic       out_valid_r;
  sym_t       out_data_r;
  logic       out_last_r;

  logic       accept;
  logic       out_free;
  logic       load_out;
  cell_ctl_t  ctl;
  node_t      root;
  sym_t       val  [LIST_SIZE];
  node_t      leaf [LIST_SIZE];

  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == CNT_W'(LEVELS)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_RUN:    load_out  = 1'b0;
      ST_FINISH: load_out  = out_free;
      default:   load_out  = 1'b0;
    endcase
    ctl.upd  = load_out && root.hit;
    ctl.init = load_out && last_r;
    ctl.pos  = root.pos;
    ctl.sym  = root.sym;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_ENCODE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_RUN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= in_tdata;
      pos_r  <= (in_tdata > MAX_POS) ? MAX_POS : in_tdata;
      last_r <= in_tlast;
    end
    if (load_out) begin
      out_data_r <= (mode_r == MODE_DECODE) ? root.sym : root.pos;
      out_last_r <= last_r;
    end
  end

  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    sym_t left_val;
    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_body
      assign left_val = val[i-1];
    end
    mtfc_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .mode     (mode_r),
      .key      (key_r),
      .pos      (pos_r),
      .ctl      (ctl),
      .left_val (left_val),
      .val      (val[i]),
      .leaf     (leaf[i])
    );
  end

  mtfc_tree #(
    .LEAVES (LIST_SIZE)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

endmodule

`default_nettype wire
